/* rtl/jpr_pkg.sv */
// ----------------------------------------------------------------------------
// jpr_pkg: shared types and constants of the J2 return mapping block
// Item formats, register codes and pipeline depths used by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jpr_pkg;

  localparam int unsigned SQRT_STAGES = 17;
  localparam int unsigned DIV_STAGES  = 16;
  localparam int unsigned QUO_W       = 32;

  localparam logic [31:0] SQRT_TWO_THIRDS = 32'd3506826112;
  localparam logic [31:0] RECIP_THREE     = 32'hAAAAAAAB;
  localparam logic [30:0] ONE_Q30         = 31'h40000000;
  localparam logic [30:0] SAT31           = 31'h7FFFFFFF;

  typedef enum logic [1:0] {
    REG_SHEAR = 2'd0,
    REG_HARD  = 2'd1,
    REG_YIELD = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] s_xx;
    logic signed [31:0] s_xy;
    logic signed [31:0] s_xz;
    logic signed [31:0] s_yx;
    logic signed [31:0] s_yy;
    logic signed [31:0] s_yz;
    logic signed [31:0] s_zx;
    logic signed [31:0] s_zy;
    logic signed [31:0] s_zz;
    logic        [30:0] hardening_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] m_xx;
    logic signed [31:0] m_xy;
    logic signed [31:0] m_xz;
    logic signed [31:0] m_yx;
    logic signed [31:0] m_yy;
    logic signed [31:0] m_yz;
    logic signed [31:0] m_zx;
    logic signed [31:0] m_zy;
    logic signed [31:0] m_zz;
    logic        [30:0] scale_ratio;
    logic        [30:0] hardening_rate;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/jpr_isqrt.sv */
// ----------------------------------------------------------------------------
// jpr_isqrt: pipelined integer square root
// Floor square root of a 68-bit radicand, two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jpr_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [67:0] rad_i,
  output logic [33:0] root_o
);

  localparam int unsigned ST = jpr_pkg::SQRT_STAGES;

  logic [67:0] rad_q  [ST];
  logic [35:0] rem_q  [ST];
  logic [33:0] root_q [ST];

  for (genvar k = 0; k < ST; k++) begin : g_st
    logic [67:0] rad_s;
    logic [35:0] rem_s;
    logic [33:0] root_s;
    logic [67:0] rad_d;
    logic [35:0] rem_d;
    logic [33:0] root_d;

    if (k == 0) begin : g_first
      assign rad_s  = rad_i;
      assign rem_s  = '0;
      assign root_s = '0;
    end else begin : g_next
      assign rad_s  = rad_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
    end

    always_comb begin
      logic [37:0] t;
      logic [37:0] trial;
      rad_d  = rad_s;
      rem_d  = rem_s;
      root_d = root_s;
      for (int b = 0; b < 2; b++) begin
        t     = {rem_d, rad_d[67:66]};
        trial = {2'b00, root_d, 2'b01};
        rad_d = {rad_d[65:0], 2'b00};
        if (t >= trial) begin
          rem_d  = 36'(t - trial);
          root_d = {root_d[32:0], 1'b1};
        end else begin
          rem_d  = t[35:0];
          root_d = {root_d[32:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[ST-1];

endmodule

`default_nettype wire

/* rtl/jpr_div.sv */
// ----------------------------------------------------------------------------
// jpr_div: pipelined restoring divider
// Extends a partial remainder below the divisor by 32 dividend bits and
// returns the 32 quotient bits, two bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jpr_div #(
  parameter int unsigned DW = 34
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [31:0]   low_i,
  input  logic [DW-1:0] div_i,
  output logic [31:0]   quo_o
);

  localparam int unsigned ST  = jpr_pkg::DIV_STAGES;
  localparam int unsigned PER = jpr_pkg::QUO_W / jpr_pkg::DIV_STAGES;

  logic [DW-1:0] rem_q [ST];
  logic [31:0]   low_q [ST];
  logic [DW-1:0] div_q [ST];
  logic [31:0]   quo_q [ST];

  for (genvar k = 0; k < ST; k++) begin : g_st
    logic [DW-1:0] rem_s;
    logic [31:0]   low_s;
    logic [DW-1:0] div_s;
    logic [31:0]   quo_s;
    logic [DW-1:0] rem_d;
    logic [31:0]   low_d;
    logic [31:0]   quo_d;

    if (k == 0) begin : g_first
      assign rem_s = rem_i;
      assign low_s = low_i;
      assign div_s = div_i;
      assign quo_s = '0;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign low_s = low_q[k-1];
      assign div_s = div_q[k-1];
      assign quo_s = quo_q[k-1];
    end

    always_comb begin
      logic [DW:0] t;
      rem_d = rem_s;
      low_d = low_s;
      quo_d = quo_s;
      for (int b = 0; b < PER; b++) begin
        t     = {rem_d, low_d[31]};
        low_d = {low_d[30:0], 1'b0};
        if (t >= {1'b0, div_s}) begin
          rem_d = DW'(t - {1'b0, div_s});
          quo_d = {quo_d[30:0], 1'b1};
        end else begin
          rem_d = t[DW-1:0];
          quo_d = {quo_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        low_q[k] <= low_d;
        div_q[k] <= div_s;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[ST-1];

endmodule

`default_nettype wire

/* rtl/j2_plastic_return_mapping.sv */
// ----------------------------------------------------------------------------
// j2_plastic_return_mapping: J2 radial return with linear hardening
// One deviatoric stress tensor and hardening factor in, one mapped tensor,
// scale ratio and hardening rate out.
//
// Input items arrive on in_valid_i/in_ready_o, results leave on
// out_valid_o/out_ready_i. Registers G, H and sigma_y are written on the
// cfg channel (index 0, 1, 2; other indexes are dropped), always ready;
// write them only while no item is in flight.
// From acceptance to the result in the output register, an item passes the
// product and sum stages, the square root (two root bits per stage), the
// yield test, the two dividers (two quotient bits per stage), the scaling
// products and the output register.
// Throughput is one item per cycle. When the receiver stalls with a result
// held, the whole pipeline holds and in_ready_o drops; nothing is lost.
// Reset empties the pipeline and loads G = 1.0, H = 0, sigma_y = 1.0;
// the derived denominator G + H/3 is rebuilt in den_q after a write, H passing through h3_q first.
// ----------------------------------------------------------------------------
`default_nettype none

module j2_plastic_return_mapping #(
  parameter int unsigned DIMS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [30:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jpr_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jpr_pkg::out_item_t  out_item_o
);

  localparam int unsigned SQ = jpr_pkg::SQRT_STAGES;
  localparam int unsigned DV = jpr_pkg::DIV_STAGES;

  typedef struct packed {
    logic [8:0][31:0] s;
    logic             big;
    logic [34:0]      lim;
  } side_a_t;

  typedef struct packed {
    logic [8:0][31:0] s;
    logic             plastic;
    logic             sat;
  } side_b_t;

  logic en;

  logic [30:0] shear_q, hard_q, yield_q;
  logic [29:0] h3_q;
  logic [31:0] den_q;
  logic [62:0] h3_prod;

  assign cfg_ready_o = 1'b1;
  assign h3_prod     = hard_q * jpr_pkg::RECIP_THREE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shear_q <= 31'd65536;
      hard_q  <= '0;
      yield_q <= 31'd65536;
      h3_q    <= '0;
      den_q   <= 32'd65536;
    end else begin
      if (cfg_valid_i) begin
        case (jpr_pkg::cfg_reg_e'(cfg_index_i))
          jpr_pkg::REG_SHEAR: shear_q <= cfg_data_i;
          jpr_pkg::REG_HARD:  hard_q  <= cfg_data_i;
          jpr_pkg::REG_YIELD: yield_q <= cfg_data_i;
          default: ;
        endcase
      end
      h3_q  <= h3_prod[62:33];
      den_q <= 32'(shear_q) + 32'(h3_q);
    end
  end

  logic [8:0][31:0] s_in;
  logic [8:0][31:0] s_msk;

  assign s_in[0] = in_item_i.s_xx;
  assign s_in[1] = in_item_i.s_xy;
  assign s_in[2] = in_item_i.s_xz;
  assign s_in[3] = in_item_i.s_yx;
  assign s_in[4] = in_item_i.s_yy;
  assign s_in[5] = in_item_i.s_yz;
  assign s_in[6] = in_item_i.s_zx;
  assign s_in[7] = in_item_i.s_zy;
  assign s_in[8] = in_item_i.s_zz;

  for (genvar g = 0; g < 9; g++) begin : g_mask
    localparam bit KEEP = ((g / 3) < DIMS) && ((g % 3) < DIMS);
    assign s_msk[g] = KEEP ? s_in[g] : 32'd0;
  end

  logic signed [63:0] p_d [6];
  logic        [61:0] hk_d;

  assign p_d[0] = $signed(s_msk[0]) * $signed(s_msk[0]);
  assign p_d[1] = $signed(s_msk[4]) * $signed(s_msk[4]);
  assign p_d[2] = $signed(s_msk[8]) * $signed(s_msk[8]);
  assign p_d[3] = $signed(s_msk[1]) * $signed(s_msk[3]);
  assign p_d[4] = $signed(s_msk[2]) * $signed(s_msk[6]);
  assign p_d[5] = $signed(s_msk[5]) * $signed(s_msk[7]);
  assign hk_d   = hard_q * in_item_i.hardening_in;

  logic               v1_q, v2_q, v3_q;
  logic [8:0][31:0]   s1_q, s2_q, s3_q;
  logic signed [63:0] p1_q [6];
  logic [61:0]        hk1_q;
  logic signed [65:0] diag2_q, off2_q;
  logic [46:0]        q2_q;
  logic [67:0]        sq3_q;
  logic               big3_q;
  logic [1:0]         qh3_q;
  logic [63:0]        mlo3_q;
  logic signed [67:0] sum_d;

  assign sum_d = 68'(diag2_q) + (68'(off2_q) <<< 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= s_msk;
      p1_q    <= p_d;
      hk1_q   <= hk_d;
      s2_q    <= s1_q;
      diag2_q <= 66'(p1_q[0]) + 66'(p1_q[1]) + 66'(p1_q[2]);
      off2_q  <= 66'(p1_q[3]) + 66'(p1_q[4]) + 66'(p1_q[5]);
      q2_q    <= 47'(hk1_q[61:16]) + 47'(yield_q);
      s3_q    <= s2_q;
      sq3_q   <= sum_d[67] ? 68'd0 : sum_d;
      big3_q  <= (q2_q[46:34] != 13'd0);
      qh3_q   <= q2_q[33:32];
      mlo3_q  <= q2_q[31:0] * jpr_pkg::SQRT_TWO_THIRDS;
    end
  end

  logic [33:0] root;

  jpr_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq3_q),
    .root_o (root)
  );

  side_a_t        sa_d;
  side_a_t        sa_q [SQ];
  logic [SQ-1:0]  va_q;

  assign sa_d.s   = s3_q;
  assign sa_d.big = big3_q;
  assign sa_d.lim = 35'(qh3_q) * 35'(jpr_pkg::SQRT_TWO_THIRDS) + 35'(mlo3_q[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
    end else if (en) begin
      va_q <= {va_q[SQ-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0] <= sa_d;
      for (int k = 1; k < SQ; k++) begin
        sa_q[k] <= sa_q[k-1];
      end
    end
  end

  logic             plastic_d, sat_d;
  logic [33:0]      f_d;
  logic             vp_q, plastic_p_q, sat_p_q;
  logic [8:0][31:0] sp_q;
  logic [33:0]      n_p_q, lim_p_q, f_p_q;

  assign plastic_d = !sa_q[SQ-1].big && (35'(root) > sa_q[SQ-1].lim);
  assign f_d       = 34'(35'(root) - sa_q[SQ-1].lim);
  assign sat_d     = (32'(f_d[33:16]) >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= va_q[SQ-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_q        <= sa_q[SQ-1].s;
      plastic_p_q <= plastic_d;
      sat_p_q     <= sat_d;
      n_p_q       <= root;
      lim_p_q     <= sa_q[SQ-1].lim[33:0];
      f_p_q       <= f_d;
    end
  end

  logic [31:0] quo_r, quo_rate;

  jpr_div #(.DW(34)) u_div_ratio (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (plastic_p_q ? lim_p_q : 34'd0),
    .low_i (32'd0),
    .div_i (n_p_q),
    .quo_o (quo_r)
  );

  jpr_div #(.DW(32)) u_div_rate (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (sat_p_q ? 32'd0 : 32'(f_p_q[33:16])),
    .low_i ({f_p_q[15:0], 16'd0}),
    .div_i (den_q),
    .quo_o (quo_rate)
  );

  side_b_t        sb_d;
  side_b_t        sb_q [DV];
  logic [DV-1:0]  vb_q;

  assign sb_d.s       = sp_q;
  assign sb_d.plastic = plastic_p_q;
  assign sb_d.sat     = sat_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else if (en) begin
      vb_q <= {vb_q[DV-2:0], vp_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_d;
      for (int k = 1; k < DV; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  logic [8:0][31:0] mag_d;
  logic [61:0]      prod_d [9];
  logic             vm_q, plastic_m_q;
  logic [8:0][31:0] s_m_q;
  logic [61:0]      prod_m_q [9];
  logic [29:0]      r_m_q;
  logic [30:0]      rate_m_q;

  for (genvar g = 0; g < 9; g++) begin : g_mag
    assign mag_d[g]  = sb_q[DV-1].s[g][31] ? (~sb_q[DV-1].s[g] + 32'd1) : sb_q[DV-1].s[g];
    assign prod_d[g] = mag_d[g] * quo_r[31:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vb_q[DV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_m_q       <= sb_q[DV-1].s;
      plastic_m_q <= sb_q[DV-1].plastic;
      prod_m_q    <= prod_d;
      r_m_q       <= quo_r[31:2];
      if (!sb_q[DV-1].plastic) begin
        rate_m_q <= '0;
      end else if (sb_q[DV-1].sat) begin
        rate_m_q <= jpr_pkg::SAT31;
      end else begin
        rate_m_q <= quo_rate[31:1];
      end
    end
  end

  logic [8:0][31:0]   m_d;
  jpr_pkg::out_item_t out_d;
  jpr_pkg::out_item_t out_q;
  logic               out_valid_q;

  for (genvar g = 0; g < 9; g++) begin : g_out
    logic [31:0] sm;
    assign sm     = prod_m_q[g][61:30];
    assign m_d[g] = !plastic_m_q ? s_m_q[g] : (s_m_q[g][31] ? (~sm + 32'd1) : sm);
  end

  assign out_d.m_xx           = m_d[0];
  assign out_d.m_xy           = m_d[1];
  assign out_d.m_xz           = m_d[2];
  assign out_d.m_yx           = m_d[3];
  assign out_d.m_yy           = m_d[4];
  assign out_d.m_yz           = m_d[5];
  assign out_d.m_zx           = m_d[6];
  assign out_d.m_zy           = m_d[7];
  assign out_d.m_zz           = m_d[8];
  assign out_d.scale_ratio    = plastic_m_q ? {1'b0, r_m_q} : jpr_pkg::ONE_Q30;
  assign out_d.hardening_rate = rate_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.scale_ratio <= jpr_pkg::ONE_Q30)
    else $error("scale ratio above one");

  a_rate_plastic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.hardening_rate != 31'd0)
      |-> out_item_o.scale_ratio != jpr_pkg::ONE_Q30)
    else $error("hardening rate on an elastic item");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vm_q) && $stable(vp_q) && $stable(va_q))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
